// ----- rtl/core/xrs_pkg.sv -----
// ----------------------------------------------------------------------------
// xrs_pkg
// Shared types, command codes and constants of the xoroshiro128++ generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrs_pkg;

    localparam int WORD_W  = 64;
    localparam int CMD_W   = 4;
    localparam int BOUND_W = 31;
    localparam int COUNT_W = 32;
    localparam int DRAW_W  = 32;
    localparam int DIV_CNT_W = $clog2(DRAW_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] GOLD_LO = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] GOLD_HI = 64'h6A09_E667_F3BC_C909;

    localparam int ROT_SUM   = 17;
    localparam int ROT_LO    = 49;
    localparam int SHL_MIX   = 21;
    localparam int ROT_HI    = 28;
    localparam int SHR_INT31 = 33;
    localparam int SHR_FR24  = 40;
    localparam int SHR_FR53  = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESEED  = 4'd0,
        CMD_RAW64   = 4'd1,
        CMD_INT31   = 4'd2,
        CMD_BOUNDED = 4'd3,
        CMD_FRAC24  = 4'd4,
        CMD_FRAC53  = 4'd5,
        CMD_BIT     = 4'd6,
        CMD_SKIP    = 4'd7,
        CMD_FORK    = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THR,
        ST_DRAW,
        ST_MOD,
        ST_SKIP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] out;
        logic [WORD_W-1:0] fork_high;
        logic [WORD_W-1:0] lo_next;
        logic [WORD_W-1:0] hi_next;
    } step_t;

    typedef struct packed {
        logic               start;
        logic [DRAW_W-1:0]  dividend;
        logic [BOUND_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [BOUND_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x, input int k);
        rotl64 = (x << k) | (x >> (WORD_W - k));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/xrs_step.sv -----
// ----------------------------------------------------------------------------
// xrs_step
// One generator step: output word, fork high word and next state.
// ----------------------------------------------------------------------------
`default_nettype none

module xrs_step (
    input  wire logic [xrs_pkg::WORD_W-1:0] lo,
    input  wire logic [xrs_pkg::WORD_W-1:0] hi,
    output xrs_pkg::step_t                  step
);

    logic [xrs_pkg::WORD_W-1:0] sum_rot;
    logic [xrs_pkg::WORD_W-1:0] mix;

    always_comb begin
        sum_rot        = xrs_pkg::rotl64(lo + hi, xrs_pkg::ROT_SUM);
        mix            = hi ^ lo;
        step.out       = sum_rot + lo;
        step.lo_next   = xrs_pkg::rotl64(lo, xrs_pkg::ROT_LO) ^ mix ^ (mix << xrs_pkg::SHL_MIX);
        step.hi_next   = xrs_pkg::rotl64(mix, xrs_pkg::ROT_HI);
        step.fork_high = sum_rot + step.hi_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/xrs_mod.sv -----
// ----------------------------------------------------------------------------
// xrs_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xrs_mod (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire xrs_pkg::div_req_t req,
    output xrs_pkg::div_rsp_t rsp
);

    logic                            busy_reg,  busy_next;
    logic                            done_reg,  done_next;
    logic [xrs_pkg::DIV_CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [xrs_pkg::DRAW_W-1:0]      dvd_reg,   dvd_next;
    logic [xrs_pkg::BOUND_W-1:0]     dsr_reg,   dsr_next;
    logic [xrs_pkg::BOUND_W-1:0]     rem_reg,   rem_next;
    logic [xrs_pkg::BOUND_W:0]       trial;
    logic [xrs_pkg::BOUND_W:0]       diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[xrs_pkg::DRAW_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[xrs_pkg::BOUND_W-1:0];
            end else begin
                rem_next = trial[xrs_pkg::BOUND_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == xrs_pkg::DIV_CNT_W'(xrs_pkg::DRAW_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/xoroshiro128pp_generator.sv -----
// ----------------------------------------------------------------------------
// xoroshiro128pp_generator
// Xoroshiro128++ generator with reseed, draw, bounded, skip and fork commands.
// ----------------------------------------------------------------------------
//  channel | ports                                          | moves
//  --------+------------------------------------------------+-------------------
//  s_      | s_valid s_ready s_command s_bound s_skip_count | one command word
//  m_      | m_valid m_ready m_value m_value_high           | one result word
//  cfg_    | cfg_we cfg_index cfg_data                      | seed register write
//
//  Reseed and unknown commands finish in ST_IDLE; draws and fork go on to ST_OUT.
//  Skip advances skip_count generator steps, one generator step per cycle.
//  Bounded draws again on each rejected draw; a nonzero bound makes two
//  passes of the shared remainder unit (threshold, then final remainder).
//  Reset is synchronous; the state comes up with the golden constants.
//  A stalled result holds in the output register while the next word enters.
// ----------------------------------------------------------------------------
`default_nettype none

module xoroshiro128pp_generator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire logic [xrs_pkg::CMD_W-1:0]       s_command,
    input  wire logic [xrs_pkg::BOUND_W-1:0]     s_bound,
    input  wire logic [xrs_pkg::COUNT_W-1:0]     s_skip_count,
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      logic [xrs_pkg::WORD_W-1:0]      m_value,
    output      logic [xrs_pkg::WORD_W-1:0]      m_value_high,
    input  wire logic                            cfg_we,
    input  wire logic [xrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [xrs_pkg::WORD_W-1:0]      cfg_data
);

    xrs_pkg::state_t               state_reg,    state_next;
    logic [xrs_pkg::WORD_W-1:0]    lo_reg,       lo_next;
    logic [xrs_pkg::WORD_W-1:0]    hi_reg,       hi_next;
    logic [xrs_pkg::WORD_W-1:0]    seed_lo_reg;
    logic [xrs_pkg::WORD_W-1:0]    seed_hi_reg;
    logic                          m_valid_reg,  m_valid_next;
    logic [xrs_pkg::COUNT_W-1:0]   cnt_reg,      cnt_next;
    logic [xrs_pkg::BOUND_W-1:0]   bound_reg,    bound_next;
    logic [xrs_pkg::BOUND_W-1:0]   thr_reg,      thr_next;
    logic [xrs_pkg::WORD_W-1:0]    res_reg,      res_next;
    logic [xrs_pkg::WORD_W-1:0]    res_high_reg, res_high_next;
    logic [xrs_pkg::WORD_W-1:0]    m_value_reg;
    logic [xrs_pkg::WORD_W-1:0]    m_value_high_reg;
    logic                          out_load;
    logic [xrs_pkg::DRAW_W-1:0]    draw;

    xrs_pkg::step_t    step;
    xrs_pkg::div_req_t div_req;
    xrs_pkg::div_rsp_t div_rsp;

    xrs_step u_step (
        .lo   (lo_reg),
        .hi   (hi_reg),
        .step (step)
    );

    xrs_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign draw    = step.out[xrs_pkg::WORD_W-1 -: xrs_pkg::DRAW_W];
    assign s_ready = (state_reg == xrs_pkg::ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        cnt_next         = cnt_reg;
        bound_next       = bound_reg;
        thr_next         = thr_reg;
        res_next         = res_reg;
        res_high_next    = res_high_reg;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {xrs_pkg::DRAW_W{1'b0}} - {1'b0, s_bound};
        div_req.divisor  = s_bound;

        unique case (state_reg)
            xrs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    res_high_next = '0;
                    unique case (xrs_pkg::cmd_t'(s_command)) inside
                        xrs_pkg::CMD_RESEED: begin
                            if ((seed_lo_reg | seed_hi_reg) == '0) begin
                                lo_next = xrs_pkg::GOLD_LO;
                                hi_next = xrs_pkg::GOLD_HI;
                            end else begin
                                lo_next = seed_lo_reg;
                                hi_next = seed_hi_reg;
                            end
                        end
                        xrs_pkg::CMD_RAW64, xrs_pkg::CMD_INT31, xrs_pkg::CMD_FRAC24,
                        xrs_pkg::CMD_FRAC53, xrs_pkg::CMD_BIT: begin
                            lo_next    = step.lo_next;
                            hi_next    = step.hi_next;
                            state_next = xrs_pkg::ST_OUT;
                            case (xrs_pkg::cmd_t'(s_command))
                                xrs_pkg::CMD_INT31:  res_next = step.out >> xrs_pkg::SHR_INT31;
                                xrs_pkg::CMD_FRAC24: res_next = step.out >> xrs_pkg::SHR_FR24;
                                xrs_pkg::CMD_FRAC53: res_next = step.out >> xrs_pkg::SHR_FR53;
                                xrs_pkg::CMD_BIT:
                                    res_next = {{(xrs_pkg::WORD_W-1){1'b0}}, step.out[0]};
                                default:             res_next = step.out;
                            endcase
                        end
                        xrs_pkg::CMD_BOUNDED: begin
                            bound_next = s_bound;
                            if (s_bound == '0) begin
                                res_next   = '0;
                                state_next = xrs_pkg::ST_OUT;
                            end else begin
                                div_req.start = 1'b1;
                                state_next    = xrs_pkg::ST_THR;
                            end
                        end
                        xrs_pkg::CMD_SKIP: begin
                            cnt_next   = s_skip_count;
                            state_next = xrs_pkg::ST_SKIP;
                        end
                        xrs_pkg::CMD_FORK: begin
                            lo_next    = step.lo_next;
                            hi_next    = step.hi_next;
                            state_next = xrs_pkg::ST_OUT;
                            if ((step.out | step.fork_high) == '0) begin
                                res_next      = xrs_pkg::GOLD_LO;
                                res_high_next = xrs_pkg::GOLD_HI;
                            end else begin
                                res_next      = step.out;
                                res_high_next = step.fork_high;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            xrs_pkg::ST_THR: begin
                if (div_rsp.done) begin
                    thr_next   = div_rsp.rem;
                    state_next = xrs_pkg::ST_DRAW;
                end
            end
            xrs_pkg::ST_DRAW: begin
                lo_next = step.lo_next;
                hi_next = step.hi_next;
                if (draw >= {1'b0, thr_reg}) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = draw;
                    div_req.divisor  = bound_reg;
                    state_next       = xrs_pkg::ST_MOD;
                end
            end
            xrs_pkg::ST_MOD: begin
                if (div_rsp.done) begin
                    res_next   = {{(xrs_pkg::WORD_W-xrs_pkg::BOUND_W){1'b0}}, div_rsp.rem};
                    state_next = xrs_pkg::ST_OUT;
                end
            end
            xrs_pkg::ST_SKIP: begin
                if (cnt_reg == '0) begin
                    res_next   = '0;
                    state_next = xrs_pkg::ST_OUT;
                end else begin
                    lo_next  = step.lo_next;
                    hi_next  = step.hi_next;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            xrs_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = xrs_pkg::ST_IDLE;
                end
            end
            default: state_next = xrs_pkg::ST_IDLE;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= xrs_pkg::ST_IDLE;
            lo_reg      <= xrs_pkg::GOLD_LO;
            hi_reg      <= xrs_pkg::GOLD_HI;
            seed_lo_reg <= '0;
            seed_hi_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && cfg_index == xrs_pkg::REG_SEED_LOW) begin
                seed_lo_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == xrs_pkg::REG_SEED_HIGH) begin
                seed_hi_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        bound_reg    <= bound_next;
        thr_reg      <= thr_next;
        res_reg      <= res_next;
        res_high_reg <= res_high_next;
        if (out_load) begin
            m_value_reg      <= res_reg;
            m_value_high_reg <= res_high_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_value_high = m_value_high_reg;

endmodule

`default_nettype wire

// ----- rtl/core/xrs_checker.sv -----
// ----------------------------------------------------------------------------
// xrs_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xrs_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic [xrs_pkg::CMD_W-1:0]    s_command,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [xrs_pkg::WORD_W-1:0]   m_value,
    input wire logic [xrs_pkg::WORD_W-1:0]   m_value_high
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_value_high))
        else $error("stalled result word changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reseed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == xrs_pkg::CMD_RESEED |=> s_ready)
        else $error("reseed did not finish in one cycle");

    a_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == xrs_pkg::CMD_RAW64 |=> !s_ready)
        else $error("draw accepted a word while its result was pending");

endmodule

bind xoroshiro128pp_generator xrs_checker u_checker (.*);

`default_nettype wire

// ----- bench/xoroshiro128pp_generator_test.sv -----
// ----------------------------------------------------------------------------
// xoroshiro128pp_generator_test
// Self-checking bench for the xoroshiro128++ generator. Commands go in over
// the s_ channel, and a scoreboard class predicts each result word from its
// own copy of the generator state and seed registers. Directed corner cases
// come first, then random phases with different seeds, sender idling,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xoroshiro128pp_generator_test;
    import xrs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] value_high;
    } expected_word_t;

    class draw_scoreboard;
        logic [WORD_W-1:0] gen_lo;
        logic [WORD_W-1:0] gen_hi;
        logic [WORD_W-1:0] seed_lo;
        logic [WORD_W-1:0] seed_hi;
        expected_word_t    expected_words[$];
        int                errors;

        function new();
            gen_lo  = GOLD_LO;
            gen_hi  = GOLD_HI;
            seed_lo = '0;
            seed_hi = '0;
            errors  = 0;
        endfunction

        function logic [WORD_W-1:0] rot_left(logic [WORD_W-1:0] x, int k);
            return (x << k) | (x >> (WORD_W - k));
        endfunction

        function logic [WORD_W-1:0] next_draw();
            logic [WORD_W-1:0] out;
            logic [WORD_W-1:0] mix;
            out    = rot_left(gen_lo + gen_hi, ROT_SUM) + gen_lo;
            mix    = gen_hi ^ gen_lo;
            gen_lo = rot_left(gen_lo, ROT_LO) ^ mix ^ (mix << SHL_MIX);
            gen_hi = rot_left(mix, ROT_HI);
            return out;
        endfunction

        function void load_seed(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            if (idx == REG_SEED_LOW) begin
                seed_lo = data;
            end else begin
                seed_hi = data;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [BOUND_W-1:0] bound,
                                   logic [COUNT_W-1:0] count);
            expected_word_t    w;
            logic [DRAW_W-1:0] limit;
            logic [DRAW_W-1:0] thr;
            logic [DRAW_W-1:0] draw;
            logic [WORD_W-1:0] carry;
            w.command    = cmd;
            w.value      = '0;
            w.value_high = '0;
            case (cmd)
                CMD_RESEED: begin
                    if ((seed_lo | seed_hi) == '0) begin
                        gen_lo = GOLD_LO;
                        gen_hi = GOLD_HI;
                    end else begin
                        gen_lo = seed_lo;
                        gen_hi = seed_hi;
                    end
                    return;
                end
                CMD_RAW64:  w.value = next_draw();
                CMD_INT31:  w.value = next_draw() >> SHR_INT31;
                CMD_FRAC24: w.value = next_draw() >> SHR_FR24;
                CMD_FRAC53: w.value = next_draw() >> SHR_FR53;
                CMD_BIT: begin
                    carry   = next_draw();
                    w.value = {63'd0, carry[0]};
                end
                CMD_BOUNDED: begin
                    if (bound != '0) begin
                        limit = {1'b0, bound};
                        thr   = (32'd0 - limit) % limit;
                        do begin
                            carry = next_draw();
                            draw  = carry[63:32];
                        end while (draw < thr);
                        w.value = {32'd0, draw % limit};
                    end
                end
                CMD_SKIP: begin
                    repeat (count) void'(next_draw());
                end
                CMD_FORK: begin
                    carry        = rot_left(gen_lo + gen_hi, ROT_SUM);
                    w.value      = next_draw();
                    w.value_high = carry + gen_hi;
                    if ((w.value | w.value_high) == '0) begin
                        w.value      = GOLD_LO;
                        w.value_high = GOLD_HI;
                    end
                end
                default: return;
            endcase
            expected_words.push_back(w);
        endfunction

        task report_mismatch(string msg);
            if (errors < 100) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
            errors++;
        endtask

        task check_word(logic [WORD_W-1:0] value, logic [WORD_W-1:0] value_high);
            expected_word_t w;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h %h", value_high, value));
                return;
            end
            w = expected_words.pop_front();
            if (value !== w.value) begin
                report_mismatch($sformatf("cmd %0d value %h, want %h",
                                          w.command, value, w.value));
            end
            if (value_high !== w.value_high) begin
                report_mismatch($sformatf("cmd %0d value_high %h, want %h",
                                          w.command, value_high, w.value_high));
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command;
    logic [BOUND_W-1:0]   s_bound;
    logic [COUNT_W-1:0]   s_skip_count;
    logic                 m_valid;
    logic                 m_ready;
    logic [WORD_W-1:0]    m_value;
    logic [WORD_W-1:0]    m_value_high;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    draw_scoreboard board;
    int             send_idle;
    int             recv_stall;
    int             hold_cycles;
    cmd_t           draw_cmds[5] = '{CMD_RAW64, CMD_INT31, CMD_FRAC24, CMD_FRAC53, CMD_BIT};

    xoroshiro128pp_generator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_bound      (s_bound),
        .s_skip_count (s_skip_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_value_high (m_value_high),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_word(logic [CMD_W-1:0] cmd, logic [BOUND_W-1:0] bound,
                             logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_bound      <= bound;
        s_skip_count <= count;
        do @(posedge aclk); while (!s_ready);
        board.note_command(cmd, bound, count);
    endtask

    task automatic receive_words();
        forever begin
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall);
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_word(m_value, m_value_high);
            end
        end
    endtask

    task automatic write_seeds(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SEED_LOW;
        cfg_data  <= lo;
        @(posedge aclk);
        board.load_seed(REG_SEED_LOW, lo);
        cfg_index <= REG_SEED_HIGH;
        cfg_data  <= hi;
        @(posedge aclk);
        board.load_seed(REG_SEED_HIGH, hi);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(int n_items, int s_idle, int r_stall,
                             logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi, int hold);
        int                 pick;
        int                 sel;
        logic [CMD_W-1:0]   cmd;
        logic [BOUND_W-1:0] bound;
        logic [COUNT_W-1:0] count;
        drain();
        write_seeds(lo, hi);
        send_idle   = s_idle;
        recv_stall  = r_stall;
        hold_cycles = hold;
        repeat (n_items) begin
            pick  = $urandom_range(99);
            bound = BOUND_W'($urandom());
            count = $urandom();
            if (pick < 4) begin
                cmd = CMD_RESEED;
            end else if (pick < 7) begin
                cmd = CMD_W'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
            end else if (pick < 22) begin
                cmd = CMD_BOUNDED;
                sel = $urandom_range(9);
                case (sel)
                    0: bound = '0;
                    1: bound = BOUND_W'($urandom_range(3, 1));
                    2: bound = BOUND_W'($urandom_range(255, 1));
                    3: bound = BOUND_W'(1) << $urandom_range(30, 0);
                    4: bound = 31'h7FFF_FFFF - BOUND_W'($urandom_range(3, 0));
                    5: bound = 31'h4000_0000 + BOUND_W'($urandom_range(1000, 1));
                    default: ;
                endcase
            end else if (pick < 30) begin
                cmd = CMD_SKIP;
                if ($urandom_range(99) < 3) begin
                    count = $urandom_range(2000, 256);
                end else begin
                    count = $urandom_range(24, 0);
                end
            end else if (pick < 38) begin
                cmd = CMD_FORK;
            end else begin
                cmd = draw_cmds[$urandom_range(4, 0)];
            end
            send_word(cmd, bound, count);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        board        = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = CMD_RESEED;
        s_bound      = '0;
        s_skip_count = '0;
        m_ready      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SEED_LOW;
        cfg_data     = '0;
        send_idle    = 0;
        recv_stall   = 0;
        hold_cycles  = 0;
        fork
            receive_words();
        join_none
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_seeds('0, '0);
        send_word(CMD_RAW64, '0, '0);
        send_word(CMD_RAW64, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_INT31, '0, '0);
        send_word(CMD_FRAC24, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_FRAC53, '0, '0);
        send_word(CMD_BIT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_FORK, '0, '0);
        send_word(CMD_BOUNDED, 31'd0, 32'hFFFF_FFFF);
        send_word(CMD_BOUNDED, 31'd1, '0);
        send_word(CMD_BOUNDED, 31'd2, '0);
        send_word(CMD_BOUNDED, 31'd3, '0);
        send_word(CMD_BOUNDED, 31'h7FFF_FFFF, '0);
        send_word(CMD_BOUNDED, 31'h7FFF_FFFE, '0);
        send_word(CMD_BOUNDED, 31'h4000_0001, '0);
        send_word(CMD_BOUNDED, 31'h4000_0000, '0);
        send_word(CMD_SKIP, 31'h7FFF_FFFF, 32'd0);
        send_word(CMD_SKIP, '0, 32'd1);
        send_word(CMD_SKIP, '0, 32'd7);
        send_word(CMD_SKIP, '0, 32'd100);
        send_word(CMD_RESEED, '0, '0);
        send_word(CMD_RAW64, '0, '0);
        send_word(CMD_UNKNOWN_LO, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_UNKNOWN_HI, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_FORK, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_BIT, '0, '0);
        s_valid <= 1'b0;

        run_phase(300, 0, 0, '1, '1, 0);
        run_phase(250, 47, 0, '0, {$urandom(), $urandom()}, 0);
        run_phase(250, 0, 47, {$urandom(), $urandom()}, '0, 0);
        run_phase(250, 25, 25, {$urandom(), $urandom()}, {$urandom(), $urandom()}, 0);
        run_phase(250, 0, 0, '0, '0, 400);

        while (board.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
